// ----- hw/rtl/ogu_pkg.sv -----
// ---------------------------------------------------------------------------
// ogu_pkg: shared types and constants of the occupancy grid update block
// Command and register codes, fixed widths, the beam angle table and the
// arctangent table of the bearing unit.
// ---------------------------------------------------------------------------
package ogu_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SCAN = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Cell class codes of a result item.
    localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
    localparam logic [1:0] CLASS_OCCUPIED = 2'd1;
    localparam logic [1:0] CLASS_FREE     = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MAX_RANGE     = 3'd0;
    localparam logic [2:0] REG_MIN_RANGE     = 3'd1;
    localparam logic [2:0] REG_OCC_INC       = 3'd2;
    localparam logic [2:0] REG_FREE_INC      = 3'd3;
    localparam logic [2:0] REG_OBST_THICK    = 3'd4;
    localparam logic [2:0] REG_BEAM_HALF     = 3'd5;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd6;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_MAX_RANGE  = 16'd5000;
    localparam logic [15:0] RST_MIN_RANGE  = 16'd170;
    localparam logic [15:0] RST_OCC_INC    = 16'd102;
    localparam logic [15:0] RST_FREE_INC   = 16'hFF9A;
    localparam logic [15:0] RST_OBST_THICK = 16'd200;
    localparam logic [14:0] RST_BEAM_HALF  = 15'd1820;
    localparam logic [15:0] RST_ORIGIN_X   = 16'd6000;
    localparam logic [15:0] RST_ORIGIN_Y   = 16'd5000;

    // Datapath widths: cell offsets, products, bearing unit vector and angle.
    localparam int COORD_W  = 24;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int CORD_W   = 36;
    localparam int ACC_W    = 26;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_COUNT  = 8;

    // Angle of half a turn at 2^24 units per turn.
    localparam logic signed [ACC_W-1:0] FINE_HALF_TURN = ACC_W'(8388608);

    // Result of the bearing unit.
    typedef struct packed {
        logic        done;
        logic [15:0] bearing;
    } cordic_res_t;

    // Fixed beam angles, 65536 units per turn.
    function automatic logic signed [17:0] beam_angle(input logic [2:0] idx);
        logic signed [17:0] a;
        case (idx)
            3'd0:    a = -18'sd16384;
            3'd1:    a = -18'sd6827;
            3'd2:    a = -18'sd4096;
            3'd3:    a = -18'sd1365;
            3'd4:    a = 18'sd1365;
            3'd5:    a = 18'sd4096;
            3'd6:    a = 18'sd6827;
            default: a = 18'sd16384;
        endcase
        return a;
    endfunction

    // Arctangent of 2^-i, 2^24 units per turn.
    function automatic logic signed [ACC_W-1:0] arc_step(input logic [3:0] idx);
        logic signed [ACC_W-1:0] a;
        case (idx)
            4'd0:    a = 26'sd2097152;
            4'd1:    a = 26'sd1238021;
            4'd2:    a = 26'sd654136;
            4'd3:    a = 26'sd332050;
            4'd4:    a = 26'sd166669;
            4'd5:    a = 26'sd83416;
            4'd6:    a = 26'sd41718;
            4'd7:    a = 26'sd20860;
            4'd8:    a = 26'sd10430;
            4'd9:    a = 26'sd5215;
            4'd10:   a = 26'sd2608;
            4'd11:   a = 26'sd1304;
            4'd12:   a = 26'sd652;
            4'd13:   a = 26'sd326;
            4'd14:   a = 26'sd163;
            default: a = 26'sd81;
        endcase
        return a;
    endfunction

endpackage

// ----- hw/rtl/ogu_ram.sv -----
// ---------------------------------------------------------------------------
// ogu_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module ogu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 45000
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/ogu_cordic.sv -----
// ---------------------------------------------------------------------------
// ogu_cordic: iterative vectoring CORDIC for the bearing of a cell
// Runs one micro-rotation per cycle, sixteen in all, on one shared
// shift and add/subtract datapath, and rounds the angle to 16 bits.
// ---------------------------------------------------------------------------
module ogu_cordic (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic signed [ogu_pkg::COORD_W-1:0]   dx,
    input  logic signed [ogu_pkg::COORD_W-1:0]   dy,
    output ogu_pkg::cordic_res_t                 res
);

    localparam int W = ogu_pkg::CORD_W;

    logic signed [W-1:0]             x_reg, y_reg;
    logic signed [ogu_pkg::ACC_W-1:0] acc_reg;
    logic [3:0]                      step_reg;
    logic                            busy_reg, done_reg, zero_reg;

    logic signed [W-1:0] x_in, y_in, xs, ys, x_mag, y_mag;
    logic signed [ogu_pkg::ACC_W-1:0] acc_round;

    // Scale the offsets by 256 into the working width.
    assign x_in = W'(dx) <<< 8;
    assign y_in = W'(dy) <<< 8;

    // Shifts that round toward zero.
    assign x_mag = x_reg[W-1] ? -x_reg : x_reg;
    assign y_mag = y_reg[W-1] ? -y_reg : y_reg;
    assign xs    = x_reg[W-1] ? -(x_mag >>> step_reg) : (x_mag >>> step_reg);
    assign ys    = y_reg[W-1] ? -(y_mag >>> step_reg) : (y_mag >>> step_reg);

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(ogu_pkg::CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Vector and angle registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            zero_reg <= (dx == '0) && (dy == '0);
            if (dx < 0) begin
                x_reg   <= -x_in;
                y_reg   <= -y_in;
                acc_reg <= ogu_pkg::FINE_HALF_TURN;
            end else begin
                x_reg   <= x_in;
                y_reg   <= y_in;
                acc_reg <= '0;
            end
        end else if (busy_reg) begin
            if (!y_reg[W-1]) begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + ogu_pkg::arc_step(step_reg);
            end else begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - ogu_pkg::arc_step(step_reg);
            end
        end
    end

    // Round 2^24 units per turn down to 65536.
    assign acc_round   = acc_reg + ogu_pkg::ACC_W'(128);
    assign res.done    = done_reg;
    assign res.bearing = zero_reg ? 16'd0 : acc_round[23:8];

endmodule

// ----- hw/rtl/occupancy_grid_log_odds_update.sv -----
// ---------------------------------------------------------------------------
// occupancy_grid_log_odds_update: log-odds occupancy grid with scan update
// Loads beam ranges, sweeps the grid with an inverse sensor model on a
// scan item, and reads single cells back.
// ---------------------------------------------------------------------------
//  Channel   Prefix   Handshake        Payload
//  input     s_       s_valid/s_ready  command, beam, range, pose, cell
//  result    m_       m_valid/m_ready  log_odds, cell_class
//  config    cfg_     cfg_wr_en        cfg_wr_index, cfg_wr_data
//
// After reset a clearing pass writes every grid cell, GRID_COLUMNS*GRID_ROWS
// cells (45000 by default); no item is accepted until it ends.
// A scan item sweeps every cell; a cell beyond max range skips the bearing
// unit and the beam search, and all squares go through one shared multiplier.
// One item is worked at a time; a result waiting on m_ready holds the block.
// ---------------------------------------------------------------------------
module occupancy_grid_log_odds_update #(
    parameter int GRID_COLUMNS = 300,
    parameter int GRID_ROWS    = 150,
    parameter int CELL_SIZE_MM = 100,
    parameter int BEAM_COUNT   = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_index,
    input  logic [15:0]        cfg_wr_data,
    // Input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [2:0]         s_beam_index,
    input  logic [15:0]        s_range_value,
    input  logic signed [15:0] s_robot_x,
    input  logic signed [15:0] s_robot_y,
    input  logic [15:0]        s_robot_heading,
    input  logic [8:0]         s_cell_column,
    input  logic [7:0]         s_cell_row,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_log_odds,
    output logic [1:0]         m_cell_class
);

    localparam int DEPTH     = GRID_COLUMNS * GRID_ROWS;
    localparam int AW        = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CW        = GRID_COLUMNS > 1 ? $clog2(GRID_COLUMNS) : 1;
    localparam int RW        = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;
    localparam int BEAM_USED = BEAM_COUNT < ogu_pkg::ANGLE_COUNT ?
                               BEAM_COUNT : ogu_pkg::ANGLE_COUNT;
    localparam int BIW       = BEAM_USED > 1 ? $clog2(BEAM_USED) : 1;
    localparam int HALF_CELL = CELL_SIZE_MM / 2;
    localparam int CWD       = ogu_pkg::COORD_W;
    localparam int PW        = ogu_pkg::PROD_W;

    typedef enum logic [18:0] {
        ST_CLEAR     = 19'b000_0000_0000_0000_0001,
        ST_IDLE      = 19'b000_0000_0000_0000_0010,
        ST_READ_WAIT = 19'b000_0000_0000_0000_0100,
        ST_RESP      = 19'b000_0000_0000_0000_1000,
        ST_SC_INIT   = 19'b000_0000_0000_0001_0000,
        ST_SC_ZMAX   = 19'b000_0000_0000_0010_0000,
        ST_SC_CELL   = 19'b000_0000_0000_0100_0000,
        ST_SC_SQX    = 19'b000_0000_0000_1000_0000,
        ST_SC_SQY    = 19'b000_0000_0001_0000_0000,
        ST_SC_DIST   = 19'b000_0000_0010_0000_0000,
        ST_SC_CORDIC = 19'b000_0000_0100_0000_0000,
        ST_SC_BEAM   = 19'b000_0000_1000_0000_0000,
        ST_SC_Z      = 19'b000_0001_0000_0000_0000,
        ST_SC_LIM    = 19'b000_0010_0000_0000_0000,
        ST_SC_HI     = 19'b000_0100_0000_0000_0000,
        ST_SC_LO     = 19'b000_1000_0000_0000_0000,
        ST_SC_TEST   = 19'b001_0000_0000_0000_0000,
        ST_SC_RMW    = 19'b010_0000_0000_0000_0000,
        ST_SC_NEXT   = 19'b100_0000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0]        max_range_reg, min_range_reg, obst_thick_reg;
    logic signed [15:0] occ_inc_reg, free_inc_reg, origin_x_reg, origin_y_reg;
    logic [14:0]        beam_half_reg;

    // Beam range store.
    logic [15:0] beam_range_reg [BEAM_USED];

    // Item and sweep registers.
    logic [1:0]               cmd_reg;
    logic signed [15:0]       rx_reg, ry_reg;
    logic [15:0]              heading_reg;
    logic                     rd_hit_reg;
    logic [AW-1:0]            clear_cnt_reg, addr_reg;
    logic [CW-1:0]            col_reg;
    logic [RW-1:0]            row_reg;
    logic signed [CWD-1:0]    x_base_reg, y_base_reg, dx_reg, dy_reg;
    logic signed [CWD-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]     prod_reg;
    logic [31:0]              zmax2_reg;
    logic [PW-1:0]            d2_reg;
    logic [PW-1:0]            lim2_reg, hi2_reg;
    logic signed [15:0]       phi_reg;
    logic [2:0]               beam_cnt_reg, best_reg;
    logic [16:0]              best_diff_reg;
    logic [15:0]              z_reg;
    logic signed [15:0]       inc_reg;
    logic signed [15:0]       out_log_odds_reg;
    logic [1:0]               out_class_reg;

    // Grid memory ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    ogu_pkg::cordic_res_t cordic_res;
    logic                 cordic_start;

    logic                 s_fire, read_in_grid, last_cell, last_row;
    logic [AW-1:0]        read_addr;
    logic [PW-1:0]        d2_sum;
    logic [PW+1:0]        d4;
    logic signed [17:0]   beam_diff;
    logic [16:0]          beam_abs;
    logic [17:0]          lim_raw, lim;
    logic [16:0]          max2;
    logic signed [18:0]   lo;
    logic [PW-1:0]        lo2;
    logic                 skip_cell, occ_cell;
    logic signed [16:0]   cell_sum;
    logic signed [15:0]   cell_sat;
    logic [15:0]          load_mask;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = (state_reg == ST_RESP);
    assign m_log_odds   = out_log_odds_reg;
    assign m_cell_class = out_class_reg;
    assign load_mask    = '0;

    // Address of a cell to read.
    assign read_in_grid = (32'(s_cell_column) < GRID_COLUMNS) &&
                          (32'(s_cell_row) < GRID_ROWS);
    assign read_addr    = AW'(32'(s_cell_column) * GRID_ROWS + 32'(s_cell_row));

    // Sweep position.
    assign last_row  = (row_reg == RW'(GRID_ROWS - 1));
    assign last_cell = last_row && (col_reg == CW'(GRID_COLUMNS - 1));

    // Distance and beam arithmetic.
    assign d2_sum    = d2_reg + PW'(prod_reg);
    assign d4        = {d2_reg, 2'b00};
    assign beam_diff = 18'(phi_reg) - ogu_pkg::beam_angle(beam_cnt_reg);
    assign beam_abs  = beam_diff[17] ? 17'(-beam_diff) : 17'(beam_diff);
    assign lim_raw   = {1'b0, z_reg, 1'b0} + 18'(obst_thick_reg);
    assign max2      = {max_range_reg, 1'b0};
    assign lim       = (18'(max2) < lim_raw) ? 18'(max2) : lim_raw;
    assign lo        = $signed({2'b00, z_reg, 1'b0}) - $signed({3'b000, obst_thick_reg});
    assign lo2       = PW'(prod_reg);

    // Inverse sensor model for the current cell.
    assign skip_cell = (d4 > (PW+2)'(lim2_reg)) ||
                       (best_diff_reg > 17'(beam_half_reg)) ||
                       (z_reg > max_range_reg) || (z_reg < min_range_reg);
    assign occ_cell  = (z_reg < max_range_reg) && (d4 < (PW+2)'(hi2_reg)) &&
                       (lo[18] || (d4 > (PW+2)'(lo2)));

    // Saturating cell update.
    assign cell_sum = 17'($signed(ram_rdata)) + 17'(inc_reg);
    always_comb begin
        if (cell_sum > 17'sd32767) begin
            cell_sat = 16'sh7FFF;
        end else if (cell_sum < -17'sd32768) begin
            cell_sat = -16'sh8000;
        end else begin
            cell_sat = cell_sum[15:0];
        end
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        case (state_reg)
            ST_SC_INIT: begin
                mul_a = CWD'(max_range_reg);
                mul_b = CWD'(max_range_reg);
            end
            ST_SC_SQX: begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            ST_SC_SQY: begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            ST_SC_LIM: begin
                mul_a = CWD'(lim);
                mul_b = CWD'(lim);
            end
            ST_SC_HI: begin
                mul_a = CWD'(lim_raw);
                mul_b = CWD'(lim_raw);
            end
            ST_SC_LO: begin
                mul_a = CWD'(lo);
                mul_b = CWD'(lo);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Grid memory access.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = cell_sat;
        ram_raddr = addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clear_cnt_reg;
                ram_wdata = load_mask;
            end
            ST_IDLE: begin
                ram_raddr = read_addr;
            end
            ST_SC_RMW: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ogu_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cordic_start = (state_reg == ST_SC_DIST) && (d2_sum <= PW'(zmax2_reg));

    ogu_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .res     (cordic_res)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clear_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_command == ogu_pkg::CMD_SCAN) begin
                        state_next = ST_SC_INIT;
                    end else if (s_command == ogu_pkg::CMD_READ) begin
                        state_next = ST_READ_WAIT;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_READ_WAIT: state_next = ST_RESP;
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SC_INIT: state_next = ST_SC_ZMAX;
            ST_SC_ZMAX: state_next = ST_SC_CELL;
            ST_SC_CELL: state_next = ST_SC_SQX;
            ST_SC_SQX:  state_next = ST_SC_SQY;
            ST_SC_SQY:  state_next = ST_SC_DIST;
            ST_SC_DIST: state_next = cordic_start ? ST_SC_CORDIC : ST_SC_NEXT;
            ST_SC_CORDIC: begin
                if (cordic_res.done) begin
                    state_next = ST_SC_BEAM;
                end
            end
            ST_SC_BEAM: begin
                if (beam_cnt_reg == 3'(BEAM_USED - 1)) begin
                    state_next = ST_SC_Z;
                end
            end
            ST_SC_Z:    state_next = ST_SC_LIM;
            ST_SC_LIM:  state_next = ST_SC_HI;
            ST_SC_HI:   state_next = ST_SC_LO;
            ST_SC_LO:   state_next = ST_SC_TEST;
            ST_SC_TEST: state_next = skip_cell ? ST_SC_NEXT : ST_SC_RMW;
            ST_SC_RMW:  state_next = ST_SC_NEXT;
            ST_SC_NEXT: state_next = last_cell ? ST_RESP : ST_SC_CELL;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control registers: state, counters, configuration and beam ranges.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_cnt_reg  <= '0;
            max_range_reg  <= ogu_pkg::RST_MAX_RANGE;
            min_range_reg  <= ogu_pkg::RST_MIN_RANGE;
            occ_inc_reg    <= ogu_pkg::RST_OCC_INC;
            free_inc_reg   <= ogu_pkg::RST_FREE_INC;
            obst_thick_reg <= ogu_pkg::RST_OBST_THICK;
            beam_half_reg  <= ogu_pkg::RST_BEAM_HALF;
            origin_x_reg   <= ogu_pkg::RST_ORIGIN_X;
            origin_y_reg   <= ogu_pkg::RST_ORIGIN_Y;
            for (int i = 0; i < BEAM_USED; i++) begin
                beam_range_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clear_cnt_reg <= clear_cnt_reg + AW'(1);
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    ogu_pkg::REG_MAX_RANGE:  max_range_reg  <= cfg_wr_data;
                    ogu_pkg::REG_MIN_RANGE:  min_range_reg  <= cfg_wr_data;
                    ogu_pkg::REG_OCC_INC:    occ_inc_reg    <= cfg_wr_data;
                    ogu_pkg::REG_FREE_INC:   free_inc_reg   <= cfg_wr_data;
                    ogu_pkg::REG_OBST_THICK: obst_thick_reg <= cfg_wr_data;
                    ogu_pkg::REG_BEAM_HALF:  beam_half_reg  <= cfg_wr_data[14:0];
                    ogu_pkg::REG_ORIGIN_X:   origin_x_reg   <= cfg_wr_data;
                    default:                 origin_y_reg   <= cfg_wr_data;
                endcase
            end
            // A load item stores one beam range.
            if (s_fire && (s_command == ogu_pkg::CMD_LOAD) &&
                (32'(s_beam_index) < BEAM_USED)) begin
                beam_range_reg[s_beam_index[BIW-1:0]] <= s_range_value;
            end
        end
    end

    // Datapath registers of the item and the sweep.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmd_reg          <= s_command;
                rx_reg           <= s_robot_x;
                ry_reg           <= s_robot_y;
                heading_reg      <= s_robot_heading;
                rd_hit_reg       <= read_in_grid;
                out_log_odds_reg <= '0;
                out_class_reg    <= ogu_pkg::CLASS_UNKNOWN;
            end
            ST_READ_WAIT: begin
                if (rd_hit_reg && (cmd_reg == ogu_pkg::CMD_READ)) begin
                    out_log_odds_reg <= ram_rdata;
                    if (ram_rdata[15]) begin
                        out_class_reg <= ogu_pkg::CLASS_FREE;
                    end else if (ram_rdata != '0) begin
                        out_class_reg <= ogu_pkg::CLASS_OCCUPIED;
                    end else begin
                        out_class_reg <= ogu_pkg::CLASS_UNKNOWN;
                    end
                end
            end
            ST_SC_INIT: begin
                col_reg    <= '0;
                row_reg    <= '0;
                addr_reg   <= '0;
                x_base_reg <= CWD'(HALF_CELL);
                y_base_reg <= CWD'(HALF_CELL);
            end
            ST_SC_ZMAX: begin
                zmax2_reg <= 32'(prod_reg);
            end
            ST_SC_CELL: begin
                dx_reg <= x_base_reg - CWD'(origin_x_reg) - CWD'(rx_reg);
                dy_reg <= CWD'(origin_y_reg) - y_base_reg - CWD'(ry_reg);
            end
            ST_SC_SQY: begin
                d2_reg <= PW'(prod_reg);
            end
            ST_SC_DIST: begin
                d2_reg <= d2_sum;
            end
            ST_SC_CORDIC: begin
                phi_reg       <= cordic_res.bearing - heading_reg;
                beam_cnt_reg  <= '0;
                best_reg      <= '0;
                best_diff_reg <= '1;
            end
            ST_SC_BEAM: begin
                // Nearest beam angle; the lower index wins a tie.
                if ((beam_cnt_reg == '0) || (beam_abs < best_diff_reg)) begin
                    best_diff_reg <= beam_abs;
                    best_reg      <= beam_cnt_reg;
                end
                beam_cnt_reg <= beam_cnt_reg + 3'd1;
            end
            ST_SC_Z: begin
                z_reg <= beam_range_reg[best_reg[BIW-1:0]];
            end
            ST_SC_HI: begin
                lim2_reg <= PW'(prod_reg);
            end
            ST_SC_LO: begin
                hi2_reg <= PW'(prod_reg);
            end
            ST_SC_TEST: begin
                inc_reg <= occ_cell ? occ_inc_reg : free_inc_reg;
            end
            ST_SC_NEXT: begin
                addr_reg <= addr_reg + AW'(1);
                if (last_row) begin
                    row_reg    <= '0;
                    y_base_reg <= CWD'(HALF_CELL);
                    col_reg    <= col_reg + CW'(1);
                    x_base_reg <= x_base_reg + CWD'(CELL_SIZE_MM);
                end else begin
                    row_reg    <= row_reg + RW'(1);
                    y_base_reg <= y_base_reg + CWD'(CELL_SIZE_MM);
                end
            end
            default: begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ogu_checker.sv -----
// ---------------------------------------------------------------------------
// ogu_checker: port-level checks of the occupancy grid update block
// Watches the handshakes and result fields and is bound to the top level.
// ---------------------------------------------------------------------------
module ogu_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_log_odds,
    input logic [1:0]         m_cell_class
);

    // Reset empties the result channel.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One item at a time: taking an item makes the block busy.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in work");

    // A waiting result blocks new items.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("ready for input while a result waits");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_log_odds) && $stable(m_cell_class))
        else $error("stalled result changed");

    // The class follows the sign of the value.
    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_cell_class == ogu_pkg::CLASS_OCCUPIED) == (m_log_odds > 0)) &&
                    ((m_cell_class == ogu_pkg::CLASS_FREE) == (m_log_odds < 0)))
        else $error("cell class does not match value");

endmodule

bind occupancy_grid_log_odds_update ogu_checker u_ogu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_log_odds   (m_log_odds),
    .m_cell_class (m_cell_class)
);
